@@ rtl/itr_pkg.sv @@
`timescale 1ns / 1ps
// Package for the infix to postfix converter: token and result beat types,
// kind and error codes, controller states and the controller/datapath links.
// Depends on nothing.
package itr_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [2:0] REQ_NUM = 3'd0;
  localparam logic [2:0] REQ_OP  = 3'd1;
  localparam logic [2:0] REQ_LB  = 3'd2;
  localparam logic [2:0] REQ_RB  = 3'd3;
  localparam logic [2:0] REQ_END = 3'd4;

  localparam logic [1:0] KIND_NUM = 2'd0;
  localparam logic [1:0] KIND_OP  = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;
  localparam logic [1:0] KIND_ERR = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BRACKET  = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  tok_symbol;
    logic [3:0]  tok_priority;
    logic        tok_right_assoc;
    logic [1:0]  tok_arity;
    logic [31:0] tok_value;
  } token_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_symbol;
    logic [1:0]  out_arity;
    logic [31:0] out_value;
    logic [1:0]  out_error;
    logic        out_last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_EXAM,
    ST_PUSH,
    ST_ERR_BR,
    ST_END,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       tok_load;
    logic       rd_en;
    logic       push;
    logic       pop;
    logic       clear_count;
    logic       set_disc;
    logic       clr_disc;
    logic       res_load;
    logic [1:0] res_kind;
    logic [1:0] res_err;
    logic       flush;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       discarding;
    logic       count_zero;
    logic       count_one;
    logic       count_full;
    logic       top_bracket;
    logic       top_pops;
    logic       pend_valid;
    logic       out_free;
  } status_t;

endpackage

@@ rtl/itr_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the infix to postfix converter.
// Depends on itr_pkg; drives the datapath through itr_pkg::cmd_t.
module itr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            token_valid,
  output logic            token_ready,
  input  itr_pkg::status_t st,
  output itr_pkg::cmd_t   cmd
);

  itr_pkg::state_t state, state_next;
  logic go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    token_ready = 1'b0;
    go          = !st.pend_valid || st.out_free;
    unique case (state)
      itr_pkg::ST_IDLE: begin
        token_ready = 1'b1;
        if (token_valid) begin
          cmd.tok_load = 1'b1;
          state_next   = itr_pkg::ST_DISPATCH;
        end
      end
      itr_pkg::ST_DISPATCH: begin
        priority if (st.req_type == itr_pkg::REQ_END) begin
          state_next = (!st.discarding && !st.count_zero) ? itr_pkg::ST_READ
                                                          : itr_pkg::ST_END;
        end else if (st.discarding) begin
          state_next = itr_pkg::ST_IDLE;
        end else if (st.req_type == itr_pkg::REQ_NUM) begin
          if (go) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = itr_pkg::KIND_NUM;
            state_next   = itr_pkg::ST_FINISH;
          end
        end else if (st.req_type == itr_pkg::REQ_OP) begin
          state_next = st.count_zero ? itr_pkg::ST_PUSH : itr_pkg::ST_READ;
        end else if (st.req_type == itr_pkg::REQ_LB) begin
          state_next = itr_pkg::ST_PUSH;
        end else if (st.req_type == itr_pkg::REQ_RB) begin
          state_next = st.count_zero ? itr_pkg::ST_ERR_BR : itr_pkg::ST_READ;
        end else begin
          if (go) begin
            cmd.res_load    = 1'b1;
            cmd.res_kind    = itr_pkg::KIND_ERR;
            cmd.res_err     = itr_pkg::ERR_UNKNOWN;
            cmd.clear_count = 1'b1;
            cmd.set_disc    = 1'b1;
            state_next      = itr_pkg::ST_FINISH;
          end
        end
      end
      itr_pkg::ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = itr_pkg::ST_EXAM;
      end
      itr_pkg::ST_EXAM: begin
        if (go) begin
          priority if (st.req_type == itr_pkg::REQ_END) begin
            cmd.res_load = 1'b1;
            if (st.top_bracket) begin
              cmd.res_kind    = itr_pkg::KIND_ERR;
              cmd.res_err     = itr_pkg::ERR_BRACKET;
              cmd.clear_count = 1'b1;
              cmd.set_disc    = 1'b1;
              state_next      = itr_pkg::ST_END;
            end else begin
              cmd.res_kind = itr_pkg::KIND_OP;
              cmd.pop      = 1'b1;
              state_next   = st.count_one ? itr_pkg::ST_END : itr_pkg::ST_READ;
            end
          end else if (st.req_type == itr_pkg::REQ_OP) begin
            if (st.top_pops) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = itr_pkg::KIND_OP;
              cmd.pop      = 1'b1;
              state_next   = st.count_one ? itr_pkg::ST_PUSH : itr_pkg::ST_READ;
            end else begin
              state_next = itr_pkg::ST_PUSH;
            end
          end else begin
            cmd.pop = 1'b1;
            if (st.top_bracket) begin
              state_next = itr_pkg::ST_FINISH;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_kind = itr_pkg::KIND_OP;
              state_next   = st.count_one ? itr_pkg::ST_ERR_BR : itr_pkg::ST_READ;
            end
          end
        end
      end
      itr_pkg::ST_PUSH: begin
        if (st.count_full) begin
          if (go) begin
            cmd.res_load    = 1'b1;
            cmd.res_kind    = itr_pkg::KIND_ERR;
            cmd.res_err     = itr_pkg::ERR_OVERFLOW;
            cmd.clear_count = 1'b1;
            cmd.set_disc    = 1'b1;
            state_next      = itr_pkg::ST_FINISH;
          end
        end else begin
          cmd.push   = 1'b1;
          state_next = itr_pkg::ST_FINISH;
        end
      end
      itr_pkg::ST_ERR_BR: begin
        if (go) begin
          cmd.res_load    = 1'b1;
          cmd.res_kind    = itr_pkg::KIND_ERR;
          cmd.res_err     = itr_pkg::ERR_BRACKET;
          cmd.clear_count = 1'b1;
          cmd.set_disc    = 1'b1;
          state_next      = itr_pkg::ST_FINISH;
        end
      end
      itr_pkg::ST_END: begin
        if (go) begin
          cmd.res_load    = 1'b1;
          cmd.res_kind    = itr_pkg::KIND_END;
          cmd.clear_count = 1'b1;
          cmd.clr_disc    = 1'b1;
          state_next      = itr_pkg::ST_FINISH;
        end
      end
      itr_pkg::ST_FINISH: begin
        if (!st.pend_valid) begin
          state_next = itr_pkg::ST_IDLE;
        end else if (st.out_free) begin
          cmd.flush  = 1'b1;
          state_next = itr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = itr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/itr_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the infix to postfix converter: token register, operator stack
// memory, stack count, pending result and output register. Depends on itr_pkg.
module itr_dp #(
  parameter int STACK_DEPTH = itr_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  itr_pkg::token_t  token,
  output itr_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_ready,
  input  itr_pkg::cmd_t    cmd,
  output itr_pkg::status_t st
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [15:0]      mem [STACK_DEPTH];
  itr_pkg::token_t  tok;
  logic [15:0]      rd_data;
  logic [CW-1:0]    count;
  logic [CW-1:0]    cnt_m1;
  logic             discarding;
  itr_pkg::result_t pend;
  itr_pkg::result_t pend_out;
  logic             pend_valid;
  itr_pkg::result_t res_new;
  logic [15:0]      entry;
  logic [3:0]       top_prio;
  logic             out_move;

  assign cnt_m1   = count - CW'(1);
  assign top_prio = rd_data[11:8];
  assign entry    = (tok.req_type == itr_pkg::REQ_LB) ? 16'h8000 :
                    {1'b0, tok.tok_arity, tok.tok_right_assoc, tok.tok_priority,
                     tok.tok_symbol};

  always_comb begin
    res_new           = '0;
    res_new.out_kind  = cmd.res_kind;
    res_new.out_error = '0;
    unique case (cmd.res_kind)
      itr_pkg::KIND_NUM: res_new.out_value = tok.tok_value;
      itr_pkg::KIND_OP: begin
        res_new.out_symbol = rd_data[7:0];
        res_new.out_arity  = rd_data[14:13];
      end
      itr_pkg::KIND_ERR: res_new.out_error = cmd.res_err;
      default: res_new.out_value = '0;
    endcase
  end

  always_comb begin
    pend_out          = pend;
    pend_out.out_last = cmd.flush;
  end

  assign out_move = (cmd.res_load || cmd.flush) && pend_valid;

  always_comb begin
    st             = '0;
    st.req_type    = tok.req_type;
    st.discarding  = discarding;
    st.count_zero  = (count == '0);
    st.count_one   = (count == CW'(1));
    st.count_full  = (count == CW'(STACK_DEPTH));
    st.top_bracket = rd_data[15];
    st.top_pops    = !rd_data[15] && ((top_prio > tok.tok_priority) ||
                     ((top_prio == tok.tok_priority) && !tok.tok_right_assoc));
    st.pend_valid  = pend_valid;
    st.out_free    = !result_valid || result_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.tok_load) begin
      tok <= token;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cnt_m1[AW-1:0]];
    end
    if (cmd.push) begin
      mem[count[AW-1:0]] <= entry;
    end
    if (out_move) begin
      result <= pend_out;
    end
    if (cmd.res_load) begin
      pend <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      discarding   <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      priority if (cmd.clear_count) begin
        count <= '0;
      end else if (cmd.push) begin
        count <= count + CW'(1);
      end else if (cmd.pop) begin
        count <= cnt_m1;
      end
      if (cmd.clr_disc) begin
        discarding <= 1'b0;
      end else if (cmd.set_disc) begin
        discarding <= 1'b1;
      end
      if (cmd.res_load) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if (out_move) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/infix_to_rpn_converter.sv @@
`timescale 1ns / 1ps
// Shunting-yard converter from infix tokens to postfix result beats.
// Top level; depends on itr_pkg, itr_ctrl and itr_dp.
//
// One token beat enters on token/token_valid/token_ready; result beats leave
// on result/result_valid/result_ready, with out_last set on the last beat a
// token causes. A token that causes no result (a push, a matched bracket, or
// any non-end token while errors are being discarded) produces no beat.
// The block works on one token at a time. It takes a token in the idle state,
// decodes it in the dispatch state and, unless it is discarded, ends in the
// finish state, which releases any held-back last result. Each stack entry
// that is examined passes through a registered stack read and a compare, and
// a push or a closing end or bracket error beat has a state of its own;
// receiver stalls can hold the states that load or release a result.
// The next token is taken while the previous last result still waits in the
// output register. When the receiver stalls, the block holds its place once
// both the output register and the one-entry pending result are full.
// Reset clears the stack count, the discard flag and both valid flags; the
// stack memory itself is not cleared, since only written entries are read.
module infix_to_rpn_converter #(
  parameter int STACK_DEPTH = itr_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  itr_pkg::token_t  token,
  input  logic             token_valid,
  output logic             token_ready,
  output itr_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_ready
);

  itr_pkg::cmd_t    cmd;
  itr_pkg::status_t st;

  itr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .st          (st),
    .cmd         (cmd)
  );

  itr_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .token        (token),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .st           (st)
  );

endmodule
